// ===== rtl/im2col_pkg.sv =====
// Shared types, register indexes and helpers for the im2col address generator.
package im2col_pkg;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;
  localparam int SizeW    = 9;
  localparam int ByteW    = 8;
  localparam int ProdW    = 2 * ByteW;
  localparam int CoordW   = ProdW + 2;
  localparam int LinW     = 2 * SizeW;
  localparam int OffsetW  = 24;

  typedef logic [CfgAddrW-1:0] cfg_addr_t;

  localparam cfg_addr_t CFG_SRC_HEIGHT    = 3'd0;
  localparam cfg_addr_t CFG_SRC_WIDTH     = 3'd1;
  localparam cfg_addr_t CFG_CHANNEL_COUNT = 3'd2;
  localparam cfg_addr_t CFG_FILTER_SIZE   = 3'd3;
  localparam cfg_addr_t CFG_RESULT_SIZE   = 3'd4;
  localparam cfg_addr_t CFG_STEP_SIZE     = 3'd5;
  localparam cfg_addr_t CFG_TAP_SPACING   = 3'd6;
  localparam cfg_addr_t CFG_BORDER        = 3'd7;

  // Decoded, clamped view of the register file.
  typedef struct packed {
    logic [SizeW-1:0] height;
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] channels;
    logic [ByteW-1:0] fh_last;
    logic [ByteW-1:0] fw_last;
    logic [ByteW-1:0] oh_last;
    logic [ByteW-1:0] ow_last;
    logic [ByteW-1:0] stride_y;
    logic [ByteW-1:0] stride_x;
    logic [ByteW-1:0] dil_y;
    logic [ByteW-1:0] dil_x;
    logic [ByteW-1:0] pad_top;
    logic [ByteW-1:0] pad_left;
  } cfg_t;

  // Current tap position and its end-of-patch / end-of-frame marks.
  typedef struct packed {
    logic [ByteW-1:0] out_row;
    logic [ByteW-1:0] out_col;
    logic [ByteW-1:0] tap_row;
    logic [ByteW-1:0] tap_col;
    logic             patch_last;
    logic             frame_last;
  } tap_t;

  // Last counter value for a byte count; a count of zero acts as one.
  function automatic logic [ByteW-1:0] last_index(logic [ByteW-1:0] cnt);
    last_index = (cnt == '0) ? '0 : cnt - 1'b1;
  endfunction

endpackage

// ===== rtl/im2col_gather_address_generator_top.sv =====
// Top level of the im2col gather address generator.
//
// Each request on the in_ channel yields one result on the out_ channel: the
// element offset of the next gathered run of channel_count elements of an HWC
// tensor, or a padding flag when the filter tap lies outside the image.
// Walk order is output row, output column, filter row, filter column.
// in_tdata bit 0 set restarts the walk at the first run before emitting.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata while idle.
//
// Pipeline: three register stages (tap products, bounds check and row scan,
// channel scale). Throughput: one request per cycle while out_tready is high;
// each stage loads as soon as the next one frees, so back-to-back requests
// flow without gaps. The 18x9 multiply in the last stage and the 9x9 multiply
// in the middle stage set the clock period.
// Reset: registers return to their defaults, counters to the first run and
// the pipeline empties. When out_tready is low, results stay in their stages;
// in_tready falls once all three stages hold a request.
module im2col_gather_address_generator_top import im2col_pkg::*; #(
  parameter int MAX_DIM      = 256,
  parameter int MAX_CHANNELS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  cfg_addr_t           cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [0] restart
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // [23:0] src_offset
  output logic [1:0]          out_tuser,  // [0] is_padding, [1] patch_last
  output logic                out_tlast   // frame_last
);

  cfg_t cfg;
  tap_t tap;
  logic accept;

  assign accept = in_tvalid && in_tready;

  im2col_cfg #(
    .MAX_DIM      (MAX_DIM),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  im2col_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .accept  (accept),
    .restart (in_tdata[0]),
    .tap     (tap)
  );

  im2col_addr u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .tap        (tap),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .src_offset (out_tdata),
    .is_padding (out_tuser[0]),
    .patch_last (out_tuser[1]),
    .frame_last (out_tlast)
  );

endmodule

// ===== rtl/im2col_cfg.sv =====
// Configuration register file with size clamping and field decode.
module im2col_cfg import im2col_pkg::*; #(
  parameter int MAX_DIM      = 256,
  parameter int MAX_CHANNELS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  cfg_addr_t           cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  logic [SizeW-1:0]    src_height_r, src_width_r, channel_count_r;
  logic [CfgDataW-1:0] filter_size_r, result_size_r, step_size_r, tap_spacing_r, border_r;

  function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] v, int hi);
    if (v == '0) begin
      clamp_size = SizeW'(1);
    end else if (int'(v) > hi) begin
      clamp_size = SizeW'(hi);
    end else begin
      clamp_size = v;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_height_r    <= SizeW'(1);
      src_width_r     <= SizeW'(1);
      channel_count_r <= SizeW'(1);
      filter_size_r   <= 16'h0101;
      result_size_r   <= 16'h0101;
      step_size_r     <= 16'h0101;
      tap_spacing_r   <= 16'h0101;
      border_r        <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_SRC_HEIGHT:    src_height_r    <= cfg_wdata[SizeW-1:0];
        CFG_SRC_WIDTH:     src_width_r     <= cfg_wdata[SizeW-1:0];
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[SizeW-1:0];
        CFG_FILTER_SIZE:   filter_size_r   <= cfg_wdata;
        CFG_RESULT_SIZE:   result_size_r   <= cfg_wdata;
        CFG_STEP_SIZE:     step_size_r     <= cfg_wdata;
        CFG_TAP_SPACING:   tap_spacing_r   <= cfg_wdata;
        CFG_BORDER:        border_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.height   = clamp_size(src_height_r, MAX_DIM);
    cfg.width    = clamp_size(src_width_r, MAX_DIM);
    cfg.channels = clamp_size(channel_count_r, MAX_CHANNELS);
    cfg.fh_last  = last_index(filter_size_r[15:8]);
    cfg.fw_last  = last_index(filter_size_r[7:0]);
    cfg.oh_last  = last_index(result_size_r[15:8]);
    cfg.ow_last  = last_index(result_size_r[7:0]);
    cfg.stride_y = step_size_r[15:8];
    cfg.stride_x = step_size_r[7:0];
    cfg.dil_y    = tap_spacing_r[15:8];
    cfg.dil_x    = tap_spacing_r[7:0];
    cfg.pad_top  = border_r[15:8];
    cfg.pad_left = border_r[7:0];
  end

endmodule

// ===== rtl/im2col_walk.sv =====
// Nested output/filter position counters that step once per accepted request.
module im2col_walk import im2col_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic accept,
  input  logic restart,
  output tap_t tap
);

  logic [ByteW-1:0] out_row_r, out_col_r, tap_row_r, tap_col_r;
  logic [ByteW-1:0] out_row_nxt, out_col_nxt, tap_row_nxt, tap_col_nxt;
  logic [ByteW-1:0] or_cur, oc_cur, tr_cur, tc_cur;
  logic             tc_last, tr_last, oc_last, or_last;

  always_comb begin
    or_cur = restart ? '0 : out_row_r;
    oc_cur = restart ? '0 : out_col_r;
    tr_cur = restart ? '0 : tap_row_r;
    tc_cur = restart ? '0 : tap_col_r;

    // a counter beyond its limit (config shrunk) counts as last
    tc_last = tc_cur >= cfg.fw_last;
    tr_last = tr_cur >= cfg.fh_last;
    oc_last = oc_cur >= cfg.ow_last;
    or_last = or_cur >= cfg.oh_last;

    tap.out_row    = or_cur;
    tap.out_col    = oc_cur;
    tap.tap_row    = tr_cur;
    tap.tap_col    = tc_cur;
    tap.patch_last = tc_last && tr_last;
    tap.frame_last = tc_last && tr_last && oc_last && or_last;

    out_row_nxt = or_cur;
    out_col_nxt = oc_cur;
    tap_row_nxt = tr_cur;
    tap_col_nxt = tc_cur + 1'b1;
    if (tc_last) begin
      tap_col_nxt = '0;
      tap_row_nxt = tr_cur + 1'b1;
      if (tr_last) begin
        tap_row_nxt = '0;
        out_col_nxt = oc_cur + 1'b1;
        if (oc_last) begin
          out_col_nxt = '0;
          out_row_nxt = or_last ? '0 : or_cur + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_row_r <= '0;
      out_col_r <= '0;
      tap_row_r <= '0;
      tap_col_r <= '0;
    end else if (accept) begin
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      tap_row_r <= tap_row_nxt;
      tap_col_r <= tap_col_nxt;
    end
  end

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && tap.frame_last |=>
      (out_row_r == '0 && out_col_r == '0 && tap_row_r == '0 && tap_col_r == '0))
    else $error("counters did not wrap after the last run of the frame");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !tc_last |=> tap_col_r == $past(tc_cur) + 1'b1)
    else $error("filter column did not advance");

endmodule

// ===== rtl/im2col_addr.sv =====
// Three-stage address pipeline: tap products, bounds check and row scan, channel scale.
module im2col_addr import im2col_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  tap_t               tap,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OffsetW-1:0] src_offset,
  output logic               is_padding,
  output logic               patch_last,
  output logic               frame_last
);

  logic rdy1, rdy2, rdy3;

  // stage 1: pixel-unit products
  logic             v1_r;
  logic [ProdW-1:0] row_prod_r, row_tap_r, col_prod_r, col_tap_r;
  logic             pl1_r, fl1_r;

  // stage 2: pixel index within the image
  logic                     v2_r;
  logic [LinW-1:0]          lin2_r;
  logic                     pad2_r, pl2_r, fl2_r;
  logic signed [CoordW-1:0] row_pos, col_pos;
  logic                     pad_nxt;
  logic [LinW-1:0]          lin_nxt;

  // stage 3: element offset
  logic                     v3_r;
  logic [OffsetW-1:0]       offset3_r;
  logic                     pad3_r, pl3_r, fl3_r;
  logic [LinW+SizeW-1:0]    elem_full;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    row_pos = $signed({2'b00, row_prod_r}) + $signed({2'b00, row_tap_r})
            - $signed({{(CoordW-ByteW){1'b0}}, cfg.pad_top});
    col_pos = $signed({2'b00, col_prod_r}) + $signed({2'b00, col_tap_r})
            - $signed({{(CoordW-ByteW){1'b0}}, cfg.pad_left});
    pad_nxt = (row_pos < 0) || (row_pos >= $signed({{(CoordW-SizeW){1'b0}}, cfg.height}))
           || (col_pos < 0) || (col_pos >= $signed({{(CoordW-SizeW){1'b0}}, cfg.width}));
    lin_nxt = ({{SizeW{1'b0}}, row_pos[SizeW-1:0]} * {{SizeW{1'b0}}, cfg.width})
            + {{SizeW{1'b0}}, col_pos[SizeW-1:0]};
    if (pad_nxt) begin
      lin_nxt = '0;
    end
    elem_full = {{SizeW{1'b0}}, lin2_r} * {{LinW{1'b0}}, cfg.channels};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      row_prod_r <= {{ByteW{1'b0}}, tap.out_row} * {{ByteW{1'b0}}, cfg.stride_y};
      row_tap_r  <= {{ByteW{1'b0}}, tap.tap_row} * {{ByteW{1'b0}}, cfg.dil_y};
      col_prod_r <= {{ByteW{1'b0}}, tap.out_col} * {{ByteW{1'b0}}, cfg.stride_x};
      col_tap_r  <= {{ByteW{1'b0}}, tap.tap_col} * {{ByteW{1'b0}}, cfg.dil_x};
      pl1_r      <= tap.patch_last;
      fl1_r      <= tap.frame_last;
    end
    if (rdy2 && v1_r) begin
      lin2_r <= lin_nxt;
      pad2_r <= pad_nxt;
      pl2_r  <= pl1_r;
      fl2_r  <= fl1_r;
    end
    if (rdy3 && v2_r) begin
      offset3_r <= elem_full[OffsetW-1:0];
      pad3_r    <= pad2_r;
      pl3_r     <= pl2_r;
      fl3_r     <= fl2_r;
    end
  end

  assign out_valid  = v3_r;
  assign src_offset = offset3_r;
  assign is_padding = pad3_r;
  assign patch_last = pl3_r;
  assign frame_last = fl3_r;

  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !rdy3 |=> v2_r)
    else $error("middle stage dropped a request while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && pad3_r |-> offset3_r == '0)
    else $error("padding run carries a nonzero offset");

  a_frame_in_patch: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && fl3_r |-> pl3_r)
    else $error("frame end without patch end");

endmodule
